>>> rtl/i2a_pkg.sv
package i2a_pkg;

    localparam int VALUE_WIDTH = 32;

    // Decimal digits needed for a magnitude of up to 2^(VALUE_WIDTH-1):
    // 1233/4096 is just below log10(2).
    localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int HEX_W      = 4 * HEX_DIGITS;
    localparam int SER_W      = (BCD_W > HEX_W) ? BCD_W : HEX_W;
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam logic [6:0] CHAR_ZERO         = 7'd48;
    localparam logic [6:0] CHAR_ALPHA_OFFSET = 7'd55;
    localparam logic [6:0] CHAR_MINUS        = 7'd45;
    localparam logic [3:0] DIGIT_TEN         = 4'd10;
    localparam logic [3:0] DABBLE_LIMIT      = 4'd5;
    localparam logic [3:0] DABBLE_ADJUST     = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] number;
        logic [1:0]                    base_code;
    } num_t;

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last_char;
    } chr_t;

    // Serializer controls from the sequencer.
    typedef struct packed {
        logic load_bin;
        logic load_hex;
        logic load_dec;
        logic shift;
    } ser_ctl_t;

    // Serializer status back to the sequencer.
    typedef struct packed {
        logic [6:0] digit_char;
        logic       digit_zero;
        logic       last_digit;
    } ser_sts_t;

endpackage

>>> rtl/i2a_dabble.sv
module i2a_dabble (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [i2a_pkg::VALUE_WIDTH-1:0] mag,
    output logic                            done,
    output logic [i2a_pkg::BCD_W-1:0]       bcd
);
    import i2a_pkg::*;

    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BCD_W-1:0]       adj;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   run_reg, run_next;

    // add-3 correction on every BCD digit before the next shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= DABBLE_LIMIT)
                          ? bcd_reg[4*i +: 4] + DABBLE_ADJUST
                          : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (start)
        begin
            bin_next = mag;
            bcd_next = '0;
            cnt_next = CNT_W'(VALUE_WIDTH);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = run_reg && (cnt_reg == '0);
    assign bcd  = bcd_reg;

endmodule

>>> rtl/i2a_digits.sv
module i2a_digits (
    input  logic                            clk,
    input  logic                            rst_n,
    input  i2a_pkg::ser_ctl_t               ctl,
    input  logic [i2a_pkg::VALUE_WIDTH-1:0] mag,
    input  logic [i2a_pkg::BCD_W-1:0]       bcd,
    output i2a_pkg::ser_sts_t               sts
);
    import i2a_pkg::*;

    logic [SER_W-1:0] sr_reg, sr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             wide_reg, wide_next;
    logic [3:0]       digit;

    // digits are left-aligned; top digit is always at the MSB end
    always_comb
    begin
        sr_next   = sr_reg;
        cnt_next  = cnt_reg;
        wide_next = wide_reg;
        if (ctl.load_bin)
        begin
            sr_next   = SER_W'(mag) << (SER_W - VALUE_WIDTH);
            cnt_next  = CNT_W'(VALUE_WIDTH);
            wide_next = 1'b0;
        end
        else if (ctl.load_hex)
        begin
            sr_next   = SER_W'(mag) << (SER_W - HEX_W);
            cnt_next  = CNT_W'(HEX_DIGITS);
            wide_next = 1'b1;
        end
        else if (ctl.load_dec)
        begin
            sr_next   = SER_W'(bcd) << (SER_W - BCD_W);
            cnt_next  = CNT_W'(DEC_DIGITS);
            wide_next = 1'b1;
        end
        else if (ctl.shift)
        begin
            sr_next  = wide_reg ? (sr_reg << 4) : (sr_reg << 1);
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            wide_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            wide_reg <= wide_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
    end

    always_comb
    begin
        digit = wide_reg ? sr_reg[SER_W-1 -: 4] : {3'b000, sr_reg[SER_W-1]};
        sts.digit_zero = (digit == 4'd0);
        sts.last_digit = (cnt_reg == CNT_W'(1));
        sts.digit_char = (digit < DIGIT_TEN) ? ({3'b000, digit} + CHAR_ZERO)
                                             : ({3'b000, digit} + CHAR_ALPHA_OFFSET);
    end

endmodule

>>> rtl/integer_to_ascii_radix.sv
// Sequence: a binary/hex transaction loads the digit register and skips leading zero digits,
//   then registers an optional minus sign and one character per remaining digit.
// A decimal transaction first runs the bit-serial double-dabble pass; a new number is
//   taken only after the last character of the previous one has been registered.
// Reset: rst_n is asynchronous, active low; clears sequencer, counters and output valid.
module integer_to_ascii_radix (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          num_valid,
    output logic          num_stall,
    input  i2a_pkg::num_t num_data,
    output logic          chr_valid,
    input  logic          chr_stall,
    output i2a_pkg::chr_t chr_data
);
    import i2a_pkg::*;

    state_t                 state_reg, state_next;
    logic                   neg_reg, neg_next;
    chr_t                   out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   slot_free;
    logic                   dab_start;
    logic                   dab_done;
    logic [BCD_W-1:0]       bcd;
    ser_ctl_t               ctl;
    ser_sts_t               sts;

    // Magnitude of the incoming value; the most negative value comes out
    // as 2^(VALUE_WIDTH-1), which still fits unsigned.
    assign raw = num_data.number;
    assign mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

    // One transaction in flight; new numbers wait until the last character
    // has been handed to the output register.
    assign num_stall = (state_reg != ST_IDLE);

    // Output register can take a character when empty or being drained.
    assign slot_free = !out_valid_reg || !chr_stall;

    // Decimal path: bit-serial binary to BCD, one bit per cycle.
    i2a_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .mag   (mag),
        .done  (dab_done),
        .bcd   (bcd)
    );

    // Digit shift register: one bit (binary) or one nibble (hex/BCD) per shift.
    i2a_digits u_digits (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .mag   (mag),
        .bcd   (bcd),
        .sts   (sts)
    );

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && chr_stall;
        ctl            = '0;
        dab_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (num_valid)
                begin
                    neg_next = raw[VALUE_WIDTH-1];
                    case (num_data.base_code)
                        BASE_BIN:
                        begin
                            ctl.load_bin = 1'b1;
                            state_next   = ST_SKIP;
                        end
                        BASE_HEX:
                        begin
                            ctl.load_hex = 1'b1;
                            state_next   = ST_SKIP;
                        end
                        BASE_DEC:
                        begin
                            dab_start  = 1'b1;
                            state_next = ST_DABBLE;
                        end
                        default:
                        begin
                            // unused radix select: no characters
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DABBLE:
            begin
                if (dab_done)
                begin
                    ctl.load_dec = 1'b1;
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, but always keep the final digit
                if (sts.digit_zero && !sts.last_digit)
                begin
                    ctl.shift = 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_next.ascii_char = CHAR_MINUS;
                    out_next.last_char  = 1'b0;
                    out_valid_next      = 1'b1;
                    state_next          = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_next.ascii_char = sts.digit_char;
                    out_next.last_char  = sts.last_digit;
                    out_valid_next      = 1'b1;
                    ctl.shift           = 1'b1;
                    if (sts.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // character payload needs no reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign chr_valid = out_valid_reg;
    assign chr_data  = out_reg;

endmodule
